@@ rtl/spmg_pkg.sv @@
// Shared types, widths and constants of the sonar point monotone gate.
package spmg_pkg;

   localparam int COORD_BITS_DEF       = 16;
   localparam int MAX_FRAME_POINTS_DEF = 65536;

   localparam int RANGE_W    = 16;
   localparam int INTEN_W    = 8;
   localparam int RSUM_W     = 32;
   localparam int ISUM_W     = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [RANGE_W-1:0] MIN_RANGE_RST = RANGE_W'(1000);
   localparam logic [RANGE_W-1:0] MAX_RANGE_RST = RANGE_W'(10000);
   localparam logic [INTEN_W-1:0] THRESH_RST    = INTEN_W'(80);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_RANGE = 2'd0,
      CSR_MAX_RANGE = 2'd1,
      CSR_THRESHOLD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [RANGE_W-1:0] min_range;
      logic [RANGE_W-1:0] max_range;
      logic [INTEN_W-1:0] threshold;
   } spmg_cfg_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range;
      logic [INTEN_W-1:0] intensity;
      logic               last;
   } spmg_point_type;

   typedef enum logic [2:0] {
      FE_IDLE,
      FE_SQUARE,
      FE_SUM,
      FE_ROOT,
      FE_PUSH
   } fe_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_START,
      BK_DIV
   } bk_state_type;

endpackage

@@ rtl/spmg_front.sv @@
// Front end: captures a point, squares the coordinates and takes the root range.
module spmg_front #(
   parameter int COORD_BITS = spmg_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_BITS-1:0]  req_x_mm,
   input  logic signed [COORD_BITS-1:0]  req_y_mm,
   input  logic signed [COORD_BITS-1:0]  req_z_mm,
   input  logic [spmg_pkg::INTEN_W-1:0]  req_echo_intensity,
   input  logic                          req_last_in_frame,
   output logic                          push_valid,
   input  logic                          push_ready,
   output spmg_pkg::spmg_point_type      push_data
);
   import spmg_pkg::*;

   localparam int C     = COORD_BITS;
   localparam int SQ_W  = 2 * C;
   localparam int REM_W = C + 2;
   localparam int IT_W  = $clog2(C + 1);

   fe_state_type state_ff, state_in;

   logic [C-1:0]       ax_ff, ay_ff, az_ff;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff, sqz_ff;
   logic [SQ_W-1:0]    rad_ff, rad_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [C-1:0]       root_ff, root_in;
   logic [IT_W-1:0]    iter_ff, iter_in;
   logic [INTEN_W-1:0] inten_ff;
   logic               last_ff;
   logic [RANGE_W-1:0] range_val;

   logic [REM_W-1:0] rem_sh, trial;
   logic             take;

   assign take = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FE_IDLE:   if (req_valid) state_in = FE_SQUARE;
         FE_SQUARE: state_in = FE_SUM;
         FE_SUM:    state_in = FE_ROOT;
         FE_ROOT:   if (iter_ff == IT_W'(1)) state_in = FE_PUSH;
         FE_PUSH:   if (push_ready) state_in = FE_IDLE;
         default:   state_in = FE_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = (state_ff == FE_IDLE);
      push_valid = (state_ff == FE_PUSH);
   end

   // one root bit per step, two radicand bits consumed each time
   always_comb begin
      rem_sh  = {rem_ff[C-1:0], rad_ff[SQ_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      rad_in  = {rad_ff[SQ_W-3:0], 2'b00};
      iter_in = iter_ff - IT_W'(1);
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {root_ff[C-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {root_ff[C-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ax_ff    <= req_x_mm[C-1] ? C'(-req_x_mm) : C'(req_x_mm);
         ay_ff    <= req_y_mm[C-1] ? C'(-req_y_mm) : C'(req_y_mm);
         az_ff    <= req_z_mm[C-1] ? C'(-req_z_mm) : C'(req_z_mm);
         inten_ff <= req_echo_intensity;
         last_ff  <= req_last_in_frame;
      end
      if (state_ff == FE_SQUARE) begin
         sqx_ff <= SQ_W'(ax_ff) * SQ_W'(ax_ff);
         sqy_ff <= SQ_W'(ay_ff) * SQ_W'(ay_ff);
         sqz_ff <= SQ_W'(az_ff) * SQ_W'(az_ff);
      end
      if (state_ff == FE_SUM) begin
         // three squares of at most 2^(2C-2) each still fit 2C bits
         rad_ff  <= sqx_ff + sqy_ff + sqz_ff;
         rem_ff  <= '0;
         root_ff <= '0;
         iter_ff <= IT_W'(C);
      end
      if (state_ff == FE_ROOT) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         iter_ff <= iter_in;
      end
   end

   generate
      if (C > RANGE_W) begin : g_sat
         assign range_val = (|root_ff[C-1:RANGE_W]) ? '1 : root_ff[RANGE_W-1:0];
      end else begin : g_fit
         assign range_val = RANGE_W'(root_ff);
      end
   endgenerate

   always_comb begin
      push_data.range     = range_val;
      push_data.intensity = inten_ff;
      push_data.last      = last_ff;
   end

endmodule

@@ rtl/spmg_queue.sv @@
// Short point queue between the front end and the gate.
module spmg_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  spmg_pkg::spmg_point_type push_data,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output spmg_pkg::spmg_point_type pop_data
);
   import spmg_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   spmg_point_type   entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/spmg_div.sv @@
// Restoring divider, one quotient bit per cycle.
module spmg_div #(
   parameter int DIVIDEND_W = spmg_pkg::RSUM_W,
   parameter int DIVISOR_W  = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W:0]    rem_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff, done_ff;
   logic [DIVISOR_W:0]    rem_sh;
   logic                  fits;

   assign rem_sh   = {rem_ff[DIVISOR_W-1:0], quo_ff[DIVIDEND_W-1]};
   assign fits     = (rem_sh >= {1'b0, divisor});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(DIVIDEND_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
         rem_ff <= fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
      end
   end

endmodule

@@ rtl/spmg_back.sv @@
// Back end: monotone gate, saturating frame sums and the frame summary.
module spmg_back #(
   parameter int MAX_FRAME_POINTS = spmg_pkg::MAX_FRAME_POINTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  spmg_pkg::spmg_cfg_type         cfg,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  spmg_pkg::spmg_point_type       pop_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_accepted,
   output logic [spmg_pkg::RANGE_W-1:0]   rsp_range_mm,
   output logic                           rsp_frame_done,
   output logic                           rsp_frame_has_point,
   output logic [spmg_pkg::RANGE_W-1:0]   rsp_final_range_mm,
   output logic [spmg_pkg::INTEN_W-1:0]   rsp_final_intensity,
   output logic [spmg_pkg::RANGE_W-1:0]   rsp_mean_range_mm,
   output logic [spmg_pkg::INTEN_W-1:0]   rsp_mean_intensity
);
   import spmg_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME_POINTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_POINTS);

   bk_state_type state_ff, state_in;

   logic [RANGE_W-1:0] prev_range_ff;
   logic [INTEN_W-1:0] prev_inten_ff;
   logic [RSUM_W-1:0]  rsum_ff;
   logic [ISUM_W-1:0]  isum_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               any_ff;
   logic               hold_acc_ff;
   logic [RANGE_W-1:0] hold_range_ff;
   logic               rsp_valid_ff;

   logic               out_free, take, pass, div_start, finish;
   logic [RSUM_W:0]    rsum_wide;
   logic [ISUM_W:0]    isum_wide;
   logic               rdiv_done, idiv_done;
   logic [RSUM_W-1:0]  rquo;
   logic [ISUM_W-1:0]  iquo;
   logic [RANGE_W-1:0] mean_range;
   logic [INTEN_W-1:0] mean_inten;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign take     = pop_valid && pop_ready;
   assign pass     = (pop_data.range >= cfg.min_range) && (pop_data.range < cfg.max_range) &&
                     (pop_data.intensity > cfg.threshold) &&
                     (pop_data.range >= prev_range_ff) && (pop_data.intensity >= prev_inten_ff);
   assign rsum_wide = {1'b0, rsum_ff} + (RSUM_W + 1)'(pop_data.range);
   assign isum_wide = {1'b0, isum_ff} + (ISUM_W + 1)'(pop_data.intensity);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (take && pop_data.last) state_in = BK_START;
         BK_START: state_in = BK_DIV;
         BK_DIV:   if (rdiv_done && idiv_done && out_free) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready = (state_ff == BK_IDLE) && out_free;
      div_start = (state_ff == BK_START);
      finish    = (state_ff == BK_DIV) && rdiv_done && idiv_done && out_free;
   end

   spmg_div #(.DIVIDEND_W(RSUM_W), .DIVISOR_W(CNT_W)) u_rdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rsum_ff),
      .divisor  (count_ff),
      .done     (rdiv_done),
      .quotient (rquo)
   );

   spmg_div #(.DIVIDEND_W(ISUM_W), .DIVISOR_W(CNT_W)) u_idiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (isum_ff),
      .divisor  (count_ff),
      .done     (idiv_done),
      .quotient (iquo)
   );

   // a saturated count can leave the quotient above the field range
   always_comb begin
      if (count_ff == '0) begin
         mean_range = '0;
         mean_inten = '0;
      end else begin
         mean_range = (|rquo[RSUM_W-1:RANGE_W]) ? '1 : rquo[RANGE_W-1:0];
         mean_inten = (|iquo[ISUM_W-1:INTEN_W]) ? '1 : iquo[INTEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((take && !pop_data.last) || finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // frame state: cleared once the summary beat is loaded
   always_ff @(posedge clock) begin
      if (reset || finish) begin
         prev_range_ff <= '0;
         prev_inten_ff <= '0;
         rsum_ff       <= '0;
         isum_ff       <= '0;
         count_ff      <= '0;
         any_ff        <= 1'b0;
      end else if (take && pass) begin
         prev_range_ff <= pop_data.range;
         prev_inten_ff <= pop_data.intensity;
         rsum_ff       <= rsum_wide[RSUM_W] ? '1 : rsum_wide[RSUM_W-1:0];
         isum_ff       <= isum_wide[ISUM_W] ? '1 : isum_wide[ISUM_W-1:0];
         if (count_ff != CNT_MAX) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         any_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hold_acc_ff   <= pass;
         hold_range_ff <= pop_data.range;
      end
      if (take && !pop_data.last) begin
         rsp_accepted        <= pass;
         rsp_range_mm        <= pop_data.range;
         rsp_frame_done      <= 1'b0;
         rsp_frame_has_point <= 1'b0;
         rsp_final_range_mm  <= '0;
         rsp_final_intensity <= '0;
         rsp_mean_range_mm   <= '0;
         rsp_mean_intensity  <= '0;
      end else if (finish) begin
         rsp_accepted        <= hold_acc_ff;
         rsp_range_mm        <= hold_range_ff;
         rsp_frame_done      <= 1'b1;
         rsp_frame_has_point <= any_ff;
         rsp_final_range_mm  <= prev_range_ff;
         rsp_final_intensity <= prev_inten_ff;
         rsp_mean_range_mm   <= mean_range;
         rsp_mean_intensity  <= mean_inten;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/sonar_point_monotone_gate.sv @@
// Top level of the sonar point monotone gate: control registers and the front/back split.
// Each point passes through the front end in order: capture, square, sum of squares,
// one root bit per cycle, hand-off; the front takes the next point as soon as the
// current range is in the two-entry queue. The gate pops one point per cycle while it
// is not closing a frame and the result register is free. The last point of a frame
// then passes through the back end's start state, 32 restoring divide steps for the
// mean range with the mean intensity divide running alongside, and the step that
// loads the summary once the result register is free, before its summary beat
// appears; the front keeps filling the queue meanwhile.
// Control registers may be written only while no point is in flight.
module sonar_point_monotone_gate #(
   parameter int COORD_BITS       = spmg_pkg::COORD_BITS_DEF,
   parameter int MAX_FRAME_POINTS = spmg_pkg::MAX_FRAME_POINTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [spmg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spmg_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [COORD_BITS-1:0]     req_x_mm,
   input  logic signed [COORD_BITS-1:0]     req_y_mm,
   input  logic signed [COORD_BITS-1:0]     req_z_mm,
   input  logic [spmg_pkg::INTEN_W-1:0]     req_echo_intensity,
   input  logic                             req_last_in_frame,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_accepted,
   output logic [spmg_pkg::RANGE_W-1:0]     rsp_range_mm,
   output logic                             rsp_frame_done,
   output logic                             rsp_frame_has_point,
   output logic [spmg_pkg::RANGE_W-1:0]     rsp_final_range_mm,
   output logic [spmg_pkg::INTEN_W-1:0]     rsp_final_intensity,
   output logic [spmg_pkg::RANGE_W-1:0]     rsp_mean_range_mm,
   output logic [spmg_pkg::INTEN_W-1:0]     rsp_mean_intensity
);
   import spmg_pkg::*;

   spmg_cfg_type   cfg_ff;
   logic           push_valid, push_ready, pop_valid, pop_ready;
   spmg_point_type push_data, pop_data;

   // unknown indexes fall through and are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_range <= MIN_RANGE_RST;
         cfg_ff.max_range <= MAX_RANGE_RST;
         cfg_ff.threshold <= THRESH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_RANGE: cfg_ff.min_range <= csr_wdata[RANGE_W-1:0];
            CSR_MAX_RANGE: cfg_ff.max_range <= csr_wdata[RANGE_W-1:0];
            CSR_THRESHOLD: cfg_ff.threshold <= csr_wdata[INTEN_W-1:0];
            default: ;
         endcase
      end
   end

   spmg_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_x_mm           (req_x_mm),
      .req_y_mm           (req_y_mm),
      .req_z_mm           (req_z_mm),
      .req_echo_intensity (req_echo_intensity),
      .req_last_in_frame  (req_last_in_frame),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_data          (push_data)
   );

   spmg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   spmg_back #(.MAX_FRAME_POINTS(MAX_FRAME_POINTS)) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_data            (pop_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_accepted        (rsp_accepted),
      .rsp_range_mm        (rsp_range_mm),
      .rsp_frame_done      (rsp_frame_done),
      .rsp_frame_has_point (rsp_frame_has_point),
      .rsp_final_range_mm  (rsp_final_range_mm),
      .rsp_final_intensity (rsp_final_intensity),
      .rsp_mean_range_mm   (rsp_mean_range_mm),
      .rsp_mean_intensity  (rsp_mean_intensity)
   );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the sonar point monotone gate: directed and random frames.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spmg_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 1030;
   localparam int COORD_MAX    = 32767;
   localparam int RANGE_REACH  = 56755;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [RANGE_W-1:0] prev_range;
      logic [INTEN_W-1:0] prev_inten;
      logic [RSUM_W-1:0]  range_sum;
      logic [ISUM_W-1:0]  inten_sum;
      logic [16:0]        count;
      logic               any;
   } frame_acc_type;

   typedef struct packed {
      logic               accepted;
      logic [RANGE_W-1:0] range_mm;
      logic               frame_done;
      logic               has_point;
      logic [RANGE_W-1:0] final_range;
      logic [INTEN_W-1:0] final_inten;
      logic [RANGE_W-1:0] mean_range;
      logic [INTEN_W-1:0] mean_inten;
   } gate_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [COORD_BITS_DEF-1:0] req_x_mm = '0;
   logic signed [COORD_BITS_DEF-1:0] req_y_mm = '0;
   logic signed [COORD_BITS_DEF-1:0] req_z_mm = '0;
   logic [INTEN_W-1:0] req_echo_intensity = '0;
   logic req_last_in_frame = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_accepted;
   logic [RANGE_W-1:0] rsp_range_mm;
   logic rsp_frame_done;
   logic rsp_frame_has_point;
   logic [RANGE_W-1:0] rsp_final_range_mm;
   logic [INTEN_W-1:0] rsp_final_intensity;
   logic [RANGE_W-1:0] rsp_mean_range_mm;
   logic [INTEN_W-1:0] rsp_mean_intensity;

   spmg_cfg_type window = '{min_range: MIN_RANGE_RST, max_range: MAX_RANGE_RST,
                            threshold: THRESH_RST};
   frame_acc_type frame_acc = '0;
   gate_report_type pending_reports[$];

   int unsigned error_count = 0;
   int unsigned beats_checked = 0;
   int unsigned points_sent = 0;
   int unsigned points_passed = 0;
   int unsigned frames_closed = 0;
   int unsigned csr_writes = 0;
   int unsigned cycle_count = 0;
   int unsigned ready_hold = 0;
   bit steady_flow = 1'b0;

   sonar_point_monotone_gate dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d beats still due", cycle_count,
                  pending_reports.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int unsigned pause_length();
      return ($urandom_range(0, 4) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 9) == 0) begin
         ready_hold <= pause_length() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int b = 17; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // Gate one point against the window and the frame's running state.
   function automatic gate_report_type judge_point(logic signed [15:0] x,
                                                   logic signed [15:0] y,
                                                   logic signed [15:0] z, logic [7:0] inten,
                                                   logic last);
      gate_report_type rep;
      longint sx, sy, sz;
      longint unsigned root;
      logic [RANGE_W-1:0] range;
      logic [RSUM_W:0] rsum;
      logic [ISUM_W:0] isum;
      logic [31:0] rmean, imean;
      logic pass;
      sx = x;
      sy = y;
      sz = z;
      if (sx < 0) sx = -sx;
      if (sy < 0) sy = -sy;
      if (sz < 0) sz = -sz;
      root = floor_root(sx * sx + sy * sy + sz * sz);
      range = (root > 65535) ? '1 : root[15:0];
      pass = range >= window.min_range && range < window.max_range &&
             inten > window.threshold &&
             range >= frame_acc.prev_range && inten >= frame_acc.prev_inten;
      rep = '0;
      rep.accepted = pass;
      rep.range_mm = range;
      rep.frame_done = last;
      if (pass) begin
         frame_acc.prev_range = range;
         frame_acc.prev_inten = inten;
         rsum = {1'b0, frame_acc.range_sum} + range;
         frame_acc.range_sum = rsum[RSUM_W] ? '1 : rsum[RSUM_W-1:0];
         isum = {1'b0, frame_acc.inten_sum} + inten;
         frame_acc.inten_sum = isum[ISUM_W] ? '1 : isum[ISUM_W-1:0];
         if (frame_acc.count < MAX_FRAME_POINTS_DEF) frame_acc.count++;
         frame_acc.any = 1'b1;
         points_passed++;
      end
      if (last) begin
         rep.has_point = frame_acc.any;
         rep.final_range = frame_acc.prev_range;
         rep.final_inten = frame_acc.prev_inten;
         if (frame_acc.count != 0) begin
            rmean = frame_acc.range_sum / frame_acc.count;
            imean = frame_acc.inten_sum / frame_acc.count;
            rep.mean_range = (rmean > 65535) ? '1 : rmean[15:0];
            rep.mean_inten = (imean > 255) ? '1 : imean[7:0];
         end
         frame_acc = '0;
         frames_closed++;
      end
      return rep;
   endfunction

   task automatic flag_error(string msg);
      $display("[%0t] ERROR %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         flag_error($sformatf("beat %0d: %s is %0h, expected %0h", beats_checked, name,
                              got, want));
   endtask

   always @(posedge clock) begin
      gate_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            flag_error($sformatf("beat %0d arrived with nothing outstanding", beats_checked));
         end else begin
            want = pending_reports.pop_front();
            check_field("accepted", rsp_accepted, want.accepted);
            check_field("range_mm", rsp_range_mm, want.range_mm);
            check_field("frame_done", rsp_frame_done, want.frame_done);
            check_field("frame_has_point", rsp_frame_has_point, want.has_point);
            check_field("final_range_mm", rsp_final_range_mm, want.final_range);
            check_field("final_intensity", rsp_final_intensity, want.final_inten);
            check_field("mean_range_mm", rsp_mean_range_mm, want.mean_range);
            check_field("mean_intensity", rsp_mean_intensity, want.mean_inten);
         end
         beats_checked++;
      end
   end

   // Called on a rising edge; returns on the edge where the beat is taken.
   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic [7:0] inten, logic last);
      int unsigned gap;
      gate_report_type due;
      gap = steady_flow ? 0 : (($urandom_range(0, 2) == 0) ? pause_length() : 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_mm <= x;
      req_y_mm <= y;
      req_z_mm <= z;
      req_echo_intensity <= inten;
      req_last_in_frame <= last;
      do @(posedge clock); while (!req_ready);
      due = judge_point(x, y, z, inten, last);
      pending_reports = {pending_reports, due};
      points_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_MIN_RANGE: window.min_range = data;
         CSR_MAX_RANGE: window.max_range = data;
         CSR_THRESHOLD: window.threshold = data[INTEN_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic set_window(logic [15:0] lo, logic [15:0] hi, logic [7:0] thr);
      drain_results();
      write_reg(CSR_MIN_RANGE, lo);
      write_reg(CSR_MAX_RANGE, hi);
      // upper byte is junk; only the low byte should land
      write_reg(CSR_THRESHOLD, {8'($urandom), thr});
   endtask

   // Spread a target range over the axes, main axis first, random signs.
   function automatic void aim_at_range(int unsigned r, output logic signed [15:0] x,
                                        output logic signed [15:0] y,
                                        output logic signed [15:0] z);
      longint unsigned rr, rest, a, b, c;
      rr = r;
      a = (rr > COORD_MAX) ? COORD_MAX : rr;
      rest = rr * rr - a * a;
      b = floor_root(rest);
      if (b > COORD_MAX) b = COORD_MAX;
      rest = rest - b * b;
      c = floor_root(rest);
      if (c > COORD_MAX) c = COORD_MAX;
      x = a[15:0];
      y = b[15:0];
      z = c[15:0];
      if ($urandom_range(0, 1)) x = -x;
      if ($urandom_range(0, 1)) y = -y;
      if ($urandom_range(0, 1)) z = -z;
   endfunction

   task automatic test_reset_config();
      send_point(3000, 4000, 0, 100, 1'b0);
      send_point(6000, 0, 0, 100, 1'b0);    // equal intensity still passes
      send_point(5999, 0, 0, 200, 1'b0);    // range went down
      send_point(-7000, 0, 0, 90, 1'b1);    // intensity went down
   endtask

   task automatic test_coordinate_extremes();
      set_window(16'd0, 16'hFFFF, 8'd0);
      send_point(0, 0, 0, 8'd1, 1'b0);
      send_point(32767, 32767, 32767, 8'd0, 1'b0);
      send_point(-32768, -32768, -32768, 8'd255, 1'b1);
   endtask

   task automatic test_window_edges();
      set_window(16'd2000, 16'd3000, 8'd100);
      send_point(1999, 0, 0, 8'd101, 1'b0);
      send_point(0, 2000, 0, 8'd100, 1'b0);
      send_point(0, 0, 2000, 8'd101, 1'b0);
      send_point(-2999, 0, 0, 8'd101, 1'b0);
      send_point(3000, 0, 0, 8'd255, 1'b1);
   endtask

   task automatic test_inverted_window();
      set_window(16'd5000, 16'd5000, 8'd10);
      send_point(5000, 0, 0, 8'd200, 1'b1);
      set_window(16'd6000, 16'd5000, 8'd10);
      send_point(0, 5500, 0, 8'd200, 1'b1);
      set_window(16'd0, 16'd0, 8'd0);
      send_point(0, 0, 0, 8'd255, 1'b1);
   endtask

   task automatic test_spare_register();
      set_window(MIN_RANGE_RST, MAX_RANGE_RST, 8'd90);
      // a zero landing in any real register would change the verdicts below
      write_reg(CSR_SPARE, 16'h0000);
      send_point(500, 0, 0, 8'd95, 1'b0);
      send_point(4000, 0, 0, 8'd91, 1'b0);
      send_point(4000, 0, 0, 8'd90, 1'b1);
   endtask

   task automatic test_random_frames(int unsigned total);
      int unsigned sent, phase, budget, len, r, span, step, inten, lo, hi, drop;
      int unsigned kind;
      logic signed [15:0] x, y, z;
      sent = 0;
      phase = 0;
      while (sent < total) begin
         case (phase % 5)
            0: set_window(16'd0, 16'hFFFF, 8'd0);
            3: set_window(16'hFFFF, 16'd0, 8'd255);
            default: begin
               lo = $urandom_range(0, 30000);
               if ($urandom_range(0, 7) == 0) hi = $urandom_range(0, lo);
               else hi = lo + $urandom_range(200, 30000);
               if (hi > 65535) hi = 65535;
               set_window(lo[15:0], hi[15:0], 8'($urandom_range(0, 200)));
            end
         endcase
         budget = sent + (((phase % 5) == 3) ? 40 : 170);
         while (sent < budget && sent < total) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            kind = $urandom_range(0, 19);   // mostly monotone, some noise, some broken
            steady_flow = ($urandom_range(0, 4) == 0);
            span = (window.max_range > window.min_range) ?
                   window.max_range - window.min_range : 1;
            r = window.min_range + $urandom_range(0, span / 4);
            inten = (window.threshold < 255) ?
                    window.threshold + 1 + $urandom_range(0, (254 - window.threshold) / 4) :
                    255;
            step = span / (len + 1) + 1;
            for (int i = 0; i < len; i++) begin
               if (kind >= 15 && kind < 18) begin
                  send_point(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                             i == len - 1);
               end else begin
                  if ($urandom_range(0, 4) != 0) r = r + $urandom_range(0, step);
                  inten = inten + $urandom_range(0, 2);
                  if (kind >= 18 && $urandom_range(0, 3) == 0) begin
                     drop = $urandom_range(1, 300);
                     r = (r > drop) ? r - drop : 0;
                     inten = (inten > 3) ? inten - $urandom_range(1, 3) : 0;
                  end
                  if (r > RANGE_REACH) r = RANGE_REACH;
                  if (inten > 255) inten = 255;
                  aim_at_range(r, x, y, z);
                  send_point(x, y, z, inten[7:0], i == len - 1);
               end
               sent++;
            end
         end
         steady_flow = 1'b0;
         phase++;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_config();
      test_coordinate_extremes();
      test_window_edges();
      test_inverted_window();
      test_spare_register();
      test_random_frames(RANDOM_ITEMS);
      drain_results();
      repeat (60) @(posedge clock);
      $display("Checked %0d beats: %0d points in %0d frames, %0d passed the gate.",
               beats_checked, points_sent, frames_closed, points_passed);
      $display("%0d register writes, windows from wide open to inverted, both sides stalled.",
               csr_writes);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
